FILE: design/psl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants of the punctuation and string lexer.
// Token kinds, source byte codes, position widths and the punctuation decoder.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int unsigned LineW = 20;
  localparam int unsigned ColW  = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};
  localparam logic [ColW-1:0]  ColMax  = {ColW{1'b1}};
  localparam logic [LineW-1:0] LineOne = LineW'(1);
  localparam logic [ColW-1:0]  ColOne  = ColW'(1);

  typedef enum logic [3:0] {
    KIND_LPAREN      = 4'd0,
    KIND_RPAREN      = 4'd1,
    KIND_LBRACE      = 4'd2,
    KIND_RBRACE      = 4'd3,
    KIND_LBRACKET    = 4'd4,
    KIND_RBRACKET    = 4'd5,
    KIND_COMMA       = 4'd6,
    KIND_PERIOD      = 4'd7,
    KIND_STR_CHAR    = 4'd8,
    KIND_STR_END     = 4'd9,
    KIND_END         = 4'd10,
    KIND_EOF_IN_STR  = 4'd11,
    KIND_UNKNOWN     = 4'd12
  } token_kind_t;

  localparam logic [ByteW-1:0] CH_LPAREN    = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN    = 8'h29;
  localparam logic [ByteW-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [ByteW-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [ByteW-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [ByteW-1:0] CH_COMMA     = 8'h2C;
  localparam logic [ByteW-1:0] CH_PERIOD    = 8'h2E;
  localparam logic [ByteW-1:0] CH_QUOTE     = 8'h22;
  localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_N         = 8'h6E;
  localparam logic [ByteW-1:0] CH_R         = 8'h72;
  localparam logic [ByteW-1:0] CH_T         = 8'h74;
  localparam logic [ByteW-1:0] CH_SPACE     = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB       = 8'h09;
  localparam logic [ByteW-1:0] CH_LF        = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic        hit;
    token_kind_t kind;
  } punct_t;

  function automatic punct_t punct_decode(input logic [ByteW-1:0] b);
    punct_t p;
    p.hit  = 1'b1;
    p.kind = KIND_UNKNOWN;
    unique case (b)
      CH_LPAREN:   p.kind = KIND_LPAREN;
      CH_RPAREN:   p.kind = KIND_RPAREN;
      CH_LBRACE:   p.kind = KIND_LBRACE;
      CH_RBRACE:   p.kind = KIND_RBRACE;
      CH_LBRACKET: p.kind = KIND_LBRACKET;
      CH_RBRACKET: p.kind = KIND_RBRACKET;
      CH_COMMA:    p.kind = KIND_COMMA;
      CH_PERIOD:   p.kind = KIND_PERIOD;
      default:     p.hit  = 1'b0;
    endcase
    return p;
  endfunction

endpackage

FILE: design/punctuation_and_string_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_and_string_lexer_core: byte stream to token stream lexer.
// Tracks line and column, tokenizes punctuation and decodes quoted strings.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one source byte per item in in_tdata; in_tuser set
// marks end of input instead of a byte. The out_ channel carries zero or one
// token per input item: the kind in out_tuser, the decoded string character,
// line and column in out_tdata. Positions count from 1 and saturate.
// An accepted item waits in the input register, where it is lexed
// against the current mode and position; its token is then held in the
// output register, and out_tvalid rises when it gets there. One item is
// taken every cycle while out_tready stays high. When the receiver stalls,
// the input register still takes one more item, then in_tready falls
// until the waiting token is taken.
// A synchronous reset (rst_n low) empties both registers, leaves string
// mode and sets line and column back to 1.
// ----------------------------------------------------------------------------
module punctuation_and_string_lexer_core
  import psl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] char_value, [27:8] token_line,
                                  // [43:28] token_column, [47:44] zero
  output logic [3:0]  out_tuser   // [3:0] token_kind
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_eoi_r;
  logic             s1_adv, s1_commit, in_acc;

  logic             in_string_r, in_string_nxt;
  logic             after_escape_r, after_escape_nxt;
  logic [LineW-1:0] line_count_r, line_count_nxt;
  logic [ColW-1:0]  column_count_r, column_count_nxt;
  logic [LineW-1:0] start_line_r, start_line_nxt;
  logic [ColW-1:0]  start_column_r, start_column_nxt;

  logic             tok_emit;
  token_kind_t      tok_kind;
  logic [ByteW-1:0] tok_char;
  logic [LineW-1:0] tok_line;
  logic [ColW-1:0]  tok_col;
  logic [LineW-1:0] adv_line;
  logic [ColW-1:0]  adv_col;
  punct_t           punct;

  logic             out_valid_r, out_valid_nxt;
  token_kind_t      out_kind_r;
  logic [ByteW-1:0] out_char_r;
  logic [LineW-1:0] out_line_r;
  logic [ColW-1:0]  out_col_r;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_commit = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_commit ? 1'b0 : s1_valid_r);

  always_comb begin
    if (s1_byte_r == CH_LF) begin
      adv_col  = ColOne;
      adv_line = (line_count_r == LineMax) ? line_count_r : line_count_r + LineOne;
    end else begin
      adv_line = line_count_r;
      adv_col  = (column_count_r == ColMax) ? column_count_r : column_count_r + ColOne;
    end
  end

  assign punct = punct_decode(s1_byte_r);

  always_comb begin
    in_string_nxt    = in_string_r;
    after_escape_nxt = after_escape_r;
    line_count_nxt   = line_count_r;
    column_count_nxt = column_count_r;
    start_line_nxt   = start_line_r;
    start_column_nxt = start_column_r;
    tok_emit         = 1'b0;
    tok_kind         = KIND_UNKNOWN;
    tok_char         = '0;
    tok_line         = line_count_r;
    tok_col          = column_count_r;
    if (s1_eoi_r) begin
      tok_emit = 1'b1;
      if (in_string_r) begin
        tok_kind         = KIND_EOF_IN_STR;
        tok_line         = start_line_r;
        tok_col          = start_column_r;
        in_string_nxt    = 1'b0;
        after_escape_nxt = 1'b0;
      end else begin
        tok_kind = KIND_END;
      end
    end else begin
      line_count_nxt   = adv_line;
      column_count_nxt = adv_col;
      if (in_string_r) begin
        tok_line = start_line_r;
        tok_col  = start_column_r;
        if (after_escape_r) begin
          after_escape_nxt = 1'b0;
          tok_emit         = 1'b1;
          tok_kind         = KIND_STR_CHAR;
          case (s1_byte_r)
            CH_N:    tok_char = CH_LF;
            CH_R:    tok_char = CH_CR;
            CH_T:    tok_char = CH_TAB;
            default: tok_char = s1_byte_r;
          endcase
        end else if (s1_byte_r == CH_QUOTE) begin
          in_string_nxt = 1'b0;
          tok_emit      = 1'b1;
          tok_kind      = KIND_STR_END;
        end else if (s1_byte_r == CH_BACKSLASH) begin
          after_escape_nxt = 1'b1;
        end else begin
          tok_emit = 1'b1;
          tok_kind = KIND_STR_CHAR;
          tok_char = s1_byte_r;
        end
      end else begin
        case (s1_byte_r)
          CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
            tok_emit = 1'b0;
          end
          CH_QUOTE: begin
            in_string_nxt    = 1'b1;
            after_escape_nxt = 1'b0;
            start_line_nxt   = line_count_r;
            start_column_nxt = column_count_r;
          end
          default: begin
            tok_emit = 1'b1;
            tok_kind = punct.hit ? punct.kind : KIND_UNKNOWN;
          end
        endcase
      end
    end
  end

  assign out_valid_nxt = s1_commit ? tok_emit : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      in_string_r    <= 1'b0;
      after_escape_r <= 1'b0;
      line_count_r   <= LineOne;
      column_count_r <= ColOne;
      start_line_r   <= LineOne;
      start_column_r <= ColOne;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_commit) begin
        in_string_r    <= in_string_nxt;
        after_escape_r <= after_escape_nxt;
        line_count_r   <= line_count_nxt;
        column_count_r <= column_count_nxt;
        start_line_r   <= start_line_nxt;
        start_column_r <= start_column_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_eoi_r  <= in_tuser;
    end
    if (s1_commit && tok_emit) begin
      out_kind_r <= tok_kind;
      out_char_r <= tok_char;
      out_line_r <= tok_line;
      out_col_r  <= tok_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_col_r, out_line_r, out_char_r};

`ifndef ASSERT_OFF
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_count_r != '0) && (column_count_r != '0))
    else $error("Line or column counter reached zero.");

  a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    after_escape_r |-> in_string_r)
    else $error("Escape pending outside a string.");

  a_eoi_leaves_string: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_commit && s1_eoi_r) |=> (!in_string_r && out_valid_r))
    else $error("End of input did not give a token or leave string mode.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tuser <= KIND_UNKNOWN))
    else $error("Token kind out of range.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !s1_commit)
    else $error("Waiting token overwritten.");
`endif

endmodule

FILE: test/tb_punctuation_and_string_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_punctuation_and_string_lexer_core: self-checking bench for the lexer core.
// A behavioral lexer in the bench predicts the token of every accepted source
// item, and each token taken from the out_ channel is compared, field by
// field, with the oldest prediction. Directed items come first: punctuation,
// whitespace, unknown bytes, strings with every escape, and end of input both
// inside and outside a string. Then come random source text with random
// stalls on both sides, and runs of blanks and line feeds that move the
// column and line counters well past their starting values.
// ----------------------------------------------------------------------------
module tb_punctuation_and_string_lexer_core
  import psl_pkg::*;
();

  typedef struct packed {
    token_kind_t      kind;
    logic [7:0]       char_value;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
  } token_t;

  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned RandomItems  = 1100;
  localparam int unsigned RunLength    = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;

  token_t           expected_tokens[$];
  int unsigned      mismatches;
  int unsigned      items_sent;
  bit               idling;

  logic             lex_in_string;
  logic             lex_escaped;
  logic [LineW-1:0] lex_line;
  logic [ColW-1:0]  lex_column;
  logic [LineW-1:0] lex_str_line;
  logic [ColW-1:0]  lex_str_column;

  logic [7:0] punct_codes[8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                  CH_LBRACKET, CH_RBRACKET, CH_COMMA, CH_PERIOD};
  logic [7:0] blank_codes[4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

  punctuation_and_string_lexer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void expect_token(token_kind_t kind, logic [7:0] char_value,
                                       logic [LineW-1:0] line, logic [ColW-1:0] column);
    token_t t;
    t.kind       = kind;
    t.char_value = char_value;
    t.line       = line;
    t.column     = column;
    expected_tokens.push_back(t);
  endfunction

  // Updates the bench's lexer state with one accepted item and queues the
  // token that it should produce.
  function automatic void lex_item(logic [7:0] b, logic eoi);
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
    logic [7:0]       decoded;
    if (eoi) begin
      if (lex_in_string) begin
        lex_in_string = 1'b0;
        lex_escaped   = 1'b0;
        expect_token(KIND_EOF_IN_STR, 8'h00, lex_str_line, lex_str_column);
      end else begin
        expect_token(KIND_END, 8'h00, lex_line, lex_column);
      end
      return;
    end
    line   = lex_line;
    column = lex_column;
    if (b == CH_LF) begin
      lex_column = ColOne;
      if (lex_line != LineMax) lex_line = lex_line + LineOne;
    end else if (lex_column != ColMax) begin
      lex_column = lex_column + ColOne;
    end
    if (lex_in_string) begin
      if (lex_escaped) begin
        lex_escaped = 1'b0;
        case (b)
          CH_N:    decoded = CH_LF;
          CH_R:    decoded = CH_CR;
          CH_T:    decoded = CH_TAB;
          default: decoded = b;
        endcase
        expect_token(KIND_STR_CHAR, decoded, lex_str_line, lex_str_column);
      end else if (b == CH_QUOTE) begin
        lex_in_string = 1'b0;
        expect_token(KIND_STR_END, 8'h00, lex_str_line, lex_str_column);
      end else if (b == CH_BACKSLASH) begin
        lex_escaped = 1'b1;
      end else begin
        expect_token(KIND_STR_CHAR, b, lex_str_line, lex_str_column);
      end
      return;
    end
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
      CH_QUOTE: begin
        lex_in_string  = 1'b1;
        lex_escaped    = 1'b0;
        lex_str_line   = line;
        lex_str_column = column;
      end
      CH_LPAREN:   expect_token(KIND_LPAREN, 8'h00, line, column);
      CH_RPAREN:   expect_token(KIND_RPAREN, 8'h00, line, column);
      CH_LBRACE:   expect_token(KIND_LBRACE, 8'h00, line, column);
      CH_RBRACE:   expect_token(KIND_RBRACE, 8'h00, line, column);
      CH_LBRACKET: expect_token(KIND_LBRACKET, 8'h00, line, column);
      CH_RBRACKET: expect_token(KIND_RBRACKET, 8'h00, line, column);
      CH_COMMA:    expect_token(KIND_COMMA, 8'h00, line, column);
      CH_PERIOD:   expect_token(KIND_PERIOD, 8'h00, line, column);
      default:     expect_token(KIND_UNKNOWN, 8'h00, line, column);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid low.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_item(b, eoi);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end_of_input();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_repeated(input logic [7:0] b, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_item(b, 1'b0);
  endtask

  task automatic wait_for_tokens();
    int unsigned cycles;
    cycles = 0;
    while (expected_tokens.size() != 0 && cycles < DrainLimit) begin
      @(negedge clk);
      cycles++;
    end
  endtask

  // Receiver side: random stalls while idling is on.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : token_check
    token_t got;
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = token_kind_t'(out_tuser);
      got.char_value = out_tdata[7:0];
      got.line       = out_tdata[27:8];
      got.column     = out_tdata[43:28];
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d char %02h line %0d column %0d",
                   got.kind, got.char_value, got.line, got.column);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.char_value !== want.char_value ||
            got.line !== want.line || got.column !== want.column) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: expected kind %0d char %02h line %0d column %0d, %s",
                     want.kind, want.char_value, want.line, want.column,
                     $sformatf("got kind %0d char %02h line %0d column %0d",
                               got.kind, got.char_value, got.line, got.column));
        end
      end
    end
  end

  task automatic test_punctuation_and_blanks();
    foreach (punct_codes[i]) send_item(punct_codes[i], 1'b0);
    send_text(";");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    foreach (blank_codes[i]) send_item(blank_codes[i], 1'b0);
    send_end_of_input();
  endtask

  task automatic test_string_escapes();
    send_text("\"a\\n\\r\\t\\\"\\\\");
    send_item(CH_BACKSLASH, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\"");
    send_text("\"\\");
    send_end_of_input();
    send_end_of_input();
  endtask

  task automatic test_long_line();
    idling = 1'b0;
    send_repeated(CH_SPACE, RunLength);
    send_text("(\"x\\t\");");
    send_item(CH_LF, 1'b0);
    send_text(")");
    idling = 1'b1;
  endtask

  task automatic send_random_string(input bit broken);
    int unsigned count;
    logic [7:0]  c;
    send_item(CH_QUOTE, 1'b0);
    count = $urandom_range(0, 12);
    for (int unsigned i = 0; i < count; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE || c == CH_BACKSLASH) begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(c, 1'b0);
      end else if ($urandom_range(0, 4) == 0) begin
        send_item(CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0:       send_item(CH_N, 1'b0);
          1:       send_item(CH_R, 1'b0);
          2:       send_item(CH_T, 1'b0);
          default: send_item(c, 1'b0);
        endcase
      end else begin
        send_item(c, 1'b0);
      end
    end
    if (broken) begin
      if ($urandom_range(0, 2) == 0) send_item(CH_BACKSLASH, 1'b0);
      send_end_of_input();
    end else begin
      send_item(CH_QUOTE, 1'b0);
    end
  endtask

  task automatic test_random_source();
    int unsigned first;
    int unsigned pick;
    bit          paused;
    first  = items_sent;
    paused = 1'b0;
    idling = 1'b1;
    while (items_sent - first < RandomItems) begin
      if (!paused && items_sent - first >= RandomItems / 2) begin
        wait_for_tokens();
        paused = 1'b1;
      end
      if (items_sent - first >= RandomItems - 250) idling = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 30)      send_item(punct_codes[$urandom_range(0, 7)], 1'b0);
      else if (pick < 40) send_item(blank_codes[$urandom_range(0, 3)], 1'b0);
      else if (pick < 50) send_item(8'($urandom_range(0, 255)), 1'b0);
      else if (pick < 85) send_random_string(1'b0);
      else if (pick < 93) send_random_string(1'b1);
      else                send_end_of_input();
    end
  endtask

  task automatic test_many_lines();
    idling = 1'b0;
    send_repeated(CH_LF, RunLength);
    send_text("(\"");
    send_item(CH_LF, 1'b0);
    send_text("a\"");
    send_item(CH_LF, 1'b0);
    send_text("]x");
    send_end_of_input();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tuser       = 1'b0;
    idling         = 1'b1;
    mismatches     = 0;
    items_sent     = 0;
    lex_in_string  = 1'b0;
    lex_escaped    = 1'b0;
    lex_line       = LineOne;
    lex_column     = ColOne;
    lex_str_line   = LineOne;
    lex_str_column = ColOne;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_punctuation_and_blanks();
    test_string_escapes();
    test_long_line();
    test_random_source();
    test_many_lines();

    in_tvalid = 1'b0;
    wait_for_tokens();
    repeat (DrainCycles) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $display("%0d expected tokens never arrived", expected_tokens.size());
      mismatches += expected_tokens.size();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
